[rtl/tnr_pkg.sv]
// ----------------------------------------------------------------------------
// Telnet receive option negotiator: shared definitions
// Command and option codes, parser phases, reply descriptors and helpers.
// ----------------------------------------------------------------------------
package tnr_pkg;

    // Telnet command bytes
    localparam logic [7:0] C_IAC  = 8'd255;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_AYT  = 8'd246;
    localparam logic [7:0] C_SE   = 8'd240;

    // Option codes
    localparam logic [7:0] OPT_BINARY   = 8'd0;
    localparam logic [7:0] OPT_ECHO     = 8'd1;
    localparam logic [7:0] OPT_SGA      = 8'd3;
    localparam logic [7:0] OPT_TTYPE    = 8'd24;
    localparam logic [7:0] OPT_LINEMODE = 8'd34;

    // Subnegotiation codes
    localparam logic [7:0] SUB_SEND  = 8'd1;
    localparam logic [7:0] SUB_IS    = 8'd0;
    localparam logic [7:0] SUB_MODE  = 8'd1;

    // Bits of the mode flag word
    localparam int F_BIN_L  = 0;
    localparam int F_BIN_R  = 1;
    localparam int F_SGA_L  = 2;
    localparam int F_SGA_R  = 3;
    localparam int F_ECHO_R = 4;
    localparam int F_LM_ACT = 5;
    localparam int F_LM_EDT = 6;
    localparam int FLAGS_W  = 7;

    // LINEMODE MODE mask bits
    localparam int MB_EDIT = 0;
    localparam int MB_ACK  = 2;

    // Result destinations
    localparam logic [1:0] DEST_USER   = 2'd0;
    localparam logic [1:0] DEST_SERVER = 2'd1;
    localparam logic [1:0] DEST_NOTICE = 2'd2;
    localparam logic [1:0] DEST_NONE   = 2'd3;

    // Configuration registers
    localparam int              CFG_IDX_W         = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LENGTH = 2'd1;
    localparam logic [31:0]     TERM_TYPE_RST     = 32'd1095652169;
    localparam logic [2:0]      TYPE_LENGTH_RST   = 3'd4;

    // The terminal type register holds four characters.
    localparam int TT_CHARS       = 4;
    localparam int TYPE_CHARS_DEF = 4;

    typedef enum logic [7:0] {
        PH_DATA   = 8'b0000_0001,
        PH_IAC    = 8'b0000_0010,
        PH_WILL   = 8'b0000_0100,
        PH_WONT   = 8'b0000_1000,
        PH_DO     = 8'b0001_0000,
        PH_DONT   = 8'b0010_0000,
        PH_SB     = 8'b0100_0000,
        PH_SB_IAC = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA,
        K_NOTICE,
        K_REPLY,
        K_TTYPE,
        K_LMACK
    } t_kind;

    // One reply, expanded into result items by the serializer.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] cmd;
        logic [7:0] arg;
        logic       line_mode;
        logic       bin_status;
    } t_desc;

    function automatic logic line_mode_of(input logic [FLAGS_W-1:0] flags);
        logic lm;
        if (flags[F_LM_ACT]) begin
            lm = flags[F_LM_EDT];
        end else if (flags[F_ECHO_R] && flags[F_SGA_R]) begin
            lm = 1'b0;
        end else begin
            lm = 1'b1;
        end
        return lm;
    endfunction

endpackage

[rtl/tnr_rx_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready stream carrying one byte from the server per transfer.
// ----------------------------------------------------------------------------
interface tnr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/tnr_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready stream carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface tnr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic       last;
    logic       line_mode;
    logic       bin_status;

    modport source (output valid, output destination, output out_byte, output last,
                    output line_mode, output bin_status, input ready);
    modport sink   (input valid, input destination, input out_byte, input last,
                    input line_mode, input bin_status, output ready);
endinterface

[rtl/tnr_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tnr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tnr_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tnr_parser.sv]
// ----------------------------------------------------------------------------
// IAC parser and option negotiation
// Input register, option table memory, parse state and reply decode.
// ----------------------------------------------------------------------------
module tnr_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output logic           o_ready,
    output logic           o_desc_valid,
    output tnr_pkg::t_desc o_desc,
    input  logic           i_desc_ready
);
    import tnr_pkg::*;

    // Input register and option table read data
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic [1:0] r_rd_bits;
    logic       r_rd_ok;

    // Option tables: bit 0 local, bit 1 remote
    logic [1:0]   r_opt_mem [256];
    logic [255:0] r_opt_vld;

    t_phase             r_phase, n_phase;
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic [1:0]         r_sub_count, n_sub_count;
    logic [7:0]         r_sub_option, n_sub_option;
    logic [7:0]         r_sub_code, n_sub_code;
    logic [7:0]         r_sub_mode, n_sub_mode;

    logic       accept;
    logic       s2_fire;
    logic       has_res;
    logic       do_store;
    logic       mem_we;
    logic       loc, rem;
    logic [1:0] n_opt_bits;
    logic [7:0] c;
    t_desc      desc;

    assign c       = r_s1_byte;
    assign accept  = i_valid && o_ready;
    assign s2_fire = r_s1_valid && (!has_res || i_desc_ready);
    assign o_ready = !r_s1_valid || s2_fire;

    assign o_desc_valid = r_s1_valid && has_res;
    assign o_desc       = desc;

    // Entries never written read as their reset value.
    assign loc = r_rd_ok ? r_rd_bits[0] : (c == OPT_BINARY || c == OPT_SGA);
    assign rem = r_rd_ok ? r_rd_bits[1] : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // A negotiation byte is always preceded by two command bytes, so the read
    // for a later negotiation never overlaps the write of an earlier one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_byte;
            r_rd_bits <= r_opt_mem[i_byte];
            r_rd_ok   <= r_opt_vld[i_byte];
        end
        if (mem_we && s2_fire) begin
            r_opt_mem[r_s1_byte] <= n_opt_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_vld <= '0;
        end else if (mem_we && s2_fire) begin
            r_opt_vld[r_s1_byte] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DATA;
            r_flags      <= '0;
            r_sub_count  <= '0;
            r_sub_option <= '0;
            r_sub_code   <= '0;
            r_sub_mode   <= '0;
        end else if (s2_fire) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_sub_count  <= n_sub_count;
            r_sub_option <= n_sub_option;
            r_sub_code   <= n_sub_code;
            r_sub_mode   <= n_sub_mode;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_sub_count  = r_sub_count;
        n_sub_option = r_sub_option;
        n_sub_code   = r_sub_code;
        n_sub_mode   = r_sub_mode;
        n_opt_bits   = {rem, loc};
        has_res      = 1'b0;
        do_store     = 1'b0;
        mem_we       = 1'b0;
        desc.kind    = K_DATA;
        desc.cmd     = 8'd0;
        desc.arg     = c;

        unique case (r_phase)
            PH_DATA: begin
                if (c == C_IAC) begin
                    n_phase = PH_IAC;
                end else begin
                    has_res = 1'b1;
                end
            end
            PH_IAC: begin
                n_phase = PH_DATA;
                unique case (c)
                    C_IAC:  has_res = 1'b1;
                    C_WILL: n_phase = PH_WILL;
                    C_WONT: n_phase = PH_WONT;
                    C_DO:   n_phase = PH_DO;
                    C_DONT: n_phase = PH_DONT;
                    C_SB: begin
                        n_phase     = PH_SB;
                        n_sub_count = 2'd0;
                    end
                    C_AYT: begin
                        has_res   = 1'b1;
                        desc.kind = K_NOTICE;
                    end
                    default: ;
                endcase
            end
            PH_WILL: begin
                n_phase   = PH_DATA;
                desc.kind = K_REPLY;
                if (c == OPT_BINARY || c == OPT_SGA || c == OPT_ECHO) begin
                    if (!rem) begin
                        n_opt_bits[1] = 1'b1;
                        mem_we        = 1'b1;
                        has_res       = 1'b1;
                        desc.cmd      = C_DO;
                        unique case (c)
                            OPT_BINARY: n_flags[F_BIN_R]  = 1'b1;
                            OPT_SGA:    n_flags[F_SGA_R]  = 1'b1;
                            default:    n_flags[F_ECHO_R] = 1'b1;
                        endcase
                    end
                end else if (rem) begin
                    n_opt_bits[1] = 1'b0;
                    mem_we        = 1'b1;
                    has_res       = 1'b1;
                    desc.cmd      = C_DONT;
                end
            end
            PH_WONT: begin
                n_phase   = PH_DATA;
                desc.kind = K_REPLY;
                if (rem) begin
                    n_opt_bits[1] = 1'b0;
                    mem_we        = 1'b1;
                    has_res       = 1'b1;
                    desc.cmd      = C_DONT;
                    unique case (c)
                        OPT_BINARY:   n_flags[F_BIN_R]  = 1'b0;
                        OPT_SGA:      n_flags[F_SGA_R]  = 1'b0;
                        OPT_ECHO:     n_flags[F_ECHO_R] = 1'b0;
                        OPT_LINEMODE: n_flags[F_LM_ACT] = 1'b0;
                        default: ;
                    endcase
                end
            end
            PH_DO: begin
                n_phase   = PH_DATA;
                desc.kind = K_REPLY;
                if (c == OPT_BINARY || c == OPT_SGA || c == OPT_TTYPE
                        || c == OPT_LINEMODE) begin
                    if (!loc) begin
                        n_opt_bits[0] = 1'b1;
                        mem_we        = 1'b1;
                        has_res       = 1'b1;
                        desc.cmd      = C_WILL;
                        unique case (c)
                            OPT_BINARY:   n_flags[F_BIN_L]  = 1'b1;
                            OPT_SGA:      n_flags[F_SGA_L]  = 1'b1;
                            OPT_LINEMODE: n_flags[F_LM_ACT] = 1'b1;
                            default: ;
                        endcase
                    end
                end else if (loc) begin
                    n_opt_bits[0] = 1'b0;
                    mem_we        = 1'b1;
                    has_res       = 1'b1;
                    desc.cmd      = C_WONT;
                end
            end
            PH_DONT: begin
                n_phase   = PH_DATA;
                desc.kind = K_REPLY;
                if (loc) begin
                    n_opt_bits[0] = 1'b0;
                    mem_we        = 1'b1;
                    has_res       = 1'b1;
                    desc.cmd      = C_WONT;
                    unique case (c)
                        OPT_BINARY:   n_flags[F_BIN_L]  = 1'b0;
                        OPT_SGA:      n_flags[F_SGA_L]  = 1'b0;
                        OPT_LINEMODE: n_flags[F_LM_ACT] = 1'b0;
                        default: ;
                    endcase
                end
            end
            PH_SB: begin
                if (c == C_IAC) begin
                    n_phase = PH_SB_IAC;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_SB_IAC: begin
                if (c == C_SE) begin
                    n_phase     = PH_DATA;
                    n_sub_count = 2'd0;
                    if (r_sub_count != 2'd0 && r_sub_option == OPT_TTYPE) begin
                        if (r_sub_count >= 2'd2 && r_sub_code == SUB_SEND) begin
                            has_res   = 1'b1;
                            desc.kind = K_TTYPE;
                        end
                    end else if (r_sub_count != 2'd0 && r_sub_option == OPT_LINEMODE) begin
                        if (r_sub_count == 2'd3 && r_sub_code == SUB_MODE) begin
                            n_flags[F_LM_EDT] = r_sub_mode[MB_EDIT];
                            desc.arg          = r_sub_mode;
                            if (r_sub_mode[MB_ACK]) begin
                                has_res   = 1'b1;
                                desc.kind = K_LMACK;
                            end
                        end
                    end
                end else begin
                    do_store = 1'b1;
                    n_phase  = PH_SB;
                end
            end
            default: n_phase = PH_DATA;
        endcase

        // Only the first three subnegotiation bytes are kept.
        if (do_store) begin
            case (r_sub_count)
                2'd0:    n_sub_option = c;
                2'd1:    n_sub_code   = c;
                2'd2:    n_sub_mode   = c;
                default: ;
            endcase
            if (r_sub_count != 2'd3) begin
                n_sub_count = r_sub_count + 2'd1;
            end
        end

        desc.line_mode  = line_mode_of(n_flags);
        desc.bin_status = n_flags[F_BIN_L] | n_flags[F_BIN_R];
    end

endmodule

[rtl/tnr_serializer.sv]
// ----------------------------------------------------------------------------
// Reply serializer
// Result register that expands one reply into result items, doubling IAC
// bytes in subnegotiation data.
// ----------------------------------------------------------------------------
module tnr_serializer #(
    parameter int TYPE_CHARS = tnr_pkg::TYPE_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc_valid,
    input  tnr_pkg::t_desc i_desc,
    output logic           o_desc_ready,
    input  logic [31:0]    i_term_type,
    input  logic [2:0]     i_type_length,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_destination,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic           o_line_mode,
    output logic           o_bin_status
);
    import tnr_pkg::*;

    localparam int MAX_CHARS = (TYPE_CHARS < TT_CHARS) ? TYPE_CHARS : TT_CHARS;

    logic       r_valid;
    t_desc      r_desc;
    logic [3:0] r_pos;
    logic       r_dup;
    logic [2:0] r_nchars;

    logic       take;
    logic       esc;
    logic       dup_next;
    logic [3:0] len_m1;
    logic [3:0] char_end;
    logic [3:0] char_off;
    logic [2:0] load_n;

    assign take         = r_valid && i_ready;
    assign o_valid      = r_valid;
    assign o_desc_ready = !r_valid || (i_ready && o_last);

    // Mode status travels with the reply, as it stood after its byte.
    assign o_line_mode  = r_desc.line_mode;
    assign o_bin_status = r_desc.bin_status;

    assign load_n   = (i_type_length > 3'(MAX_CHARS)) ? 3'(MAX_CHARS) : i_type_length;
    assign char_end = 4'd4 + {1'b0, r_nchars};
    assign char_off = r_pos - 4'd4;

    always_comb begin
        o_destination = DEST_SERVER;
        o_byte        = C_IAC;
        esc           = 1'b0;
        len_m1        = 4'd0;
        case (r_desc.kind)
            K_DATA: begin
                o_destination = DEST_USER;
                o_byte        = r_desc.arg;
            end
            K_NOTICE: begin
                o_destination = DEST_NOTICE;
                o_byte        = 8'd0;
            end
            K_REPLY: begin
                len_m1 = 4'd2;
                case (r_pos)
                    4'd0:    o_byte = C_IAC;
                    4'd1:    o_byte = r_desc.cmd;
                    default: o_byte = r_desc.arg;
                endcase
            end
            K_TTYPE: begin
                len_m1 = char_end + 4'd1;
                if (r_pos == 4'd0) begin
                    o_byte = C_IAC;
                end else if (r_pos == 4'd1) begin
                    o_byte = C_SB;
                end else if (r_pos == 4'd2) begin
                    o_byte = OPT_TTYPE;
                end else if (r_pos == 4'd3) begin
                    o_byte = SUB_IS;
                end else if (r_pos < char_end) begin
                    esc = 1'b1;
                    case (char_off[1:0])
                        2'd0:    o_byte = i_term_type[31:24];
                        2'd1:    o_byte = i_term_type[23:16];
                        2'd2:    o_byte = i_term_type[15:8];
                        default: o_byte = i_term_type[7:0];
                    endcase
                end else if (r_pos == char_end) begin
                    o_byte = C_IAC;
                end else begin
                    o_byte = C_SE;
                end
            end
            K_LMACK: begin
                len_m1 = 4'd6;
                case (r_pos)
                    4'd0: o_byte = C_IAC;
                    4'd1: o_byte = C_SB;
                    4'd2: o_byte = OPT_LINEMODE;
                    4'd3: o_byte = SUB_MODE;
                    4'd4: begin
                        o_byte = r_desc.arg;
                        esc    = 1'b1;
                    end
                    4'd5:    o_byte = C_IAC;
                    default: o_byte = C_SE;
                endcase
            end
            default: o_destination = DEST_NONE;
        endcase
    end

    // A subnegotiation data byte of 255 goes out twice; the second copy keeps the position.
    assign dup_next = esc && (o_byte == C_IAC) && !r_dup;
    assign o_last   = (r_pos == len_m1) && !dup_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_desc_valid && o_desc_ready) begin
            r_valid <= 1'b1;
        end else if (take && o_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc_valid && o_desc_ready) begin
            r_desc   <= i_desc;
            r_pos    <= 4'd0;
            r_dup    <= 1'b0;
            r_nchars <= load_n;
        end else if (take && !o_last) begin
            if (dup_next) begin
                r_dup <= 1'b1;
            end else begin
                r_pos <= r_pos + 4'd1;
                r_dup <= 1'b0;
            end
        end
    end

endmodule

[rtl/telnet_receive_option_negotiator.sv]
// ----------------------------------------------------------------------------
// Telnet receive option negotiator
// Parses received telnet bytes, answers option negotiation and
// subnegotiation, and delivers user data, server replies and notices.
//
//   Channel   Direction  Payload
//   i_rx      in         rx_byte
//   o_res     out        destination, out_byte, last, line_mode, bin_status
//   i_cfg     in         index, data (terminal type, type length)
//
// A byte is registered in the input register on transfer and decoded there;
// its reply is then loaded into the result register once that is free, and
// one item goes out per cycle while the receiver is ready. A new byte is
// taken every cycle while each byte gives at most one item and the receiver
// takes every item. A reply of n items (up to 14) holds the next byte that
// gives an item, and the input behind it, while it drains.
// Reset is synchronous; the option tables need no sweep.
// ----------------------------------------------------------------------------
module telnet_receive_option_negotiator #(
    parameter int TYPE_CHARS = tnr_pkg::TYPE_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tnr_rx_if.sink    i_rx,
    tnr_res_if.source o_res,
    tnr_cfg_if.sink   i_cfg
);
    import tnr_pkg::*;

    logic [31:0] r_term_type;
    logic [2:0]  r_type_length;

    logic  desc_valid;
    logic  desc_ready;
    t_desc desc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_type   <= TERM_TYPE_RST;
            r_type_length <= TYPE_LENGTH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TERM_TYPE:   r_term_type   <= i_cfg.data;
                CFG_TYPE_LENGTH: r_type_length <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    tnr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_rx.valid),
        .i_byte       (i_rx.rx_byte),
        .o_ready      (i_rx.ready),
        .o_desc_valid (desc_valid),
        .o_desc       (desc),
        .i_desc_ready (desc_ready)
    );

    tnr_serializer #(
        .TYPE_CHARS (TYPE_CHARS)
    ) u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc_valid  (desc_valid),
        .i_desc        (desc),
        .o_desc_ready  (desc_ready),
        .i_term_type   (r_term_type),
        .i_type_length (r_type_length),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_destination (o_res.destination),
        .o_byte        (o_res.out_byte),
        .o_last        (o_res.last),
        .o_line_mode   (o_res.line_mode),
        .o_bin_status  (o_res.bin_status)
    );

endmodule

[rtl/tnr_checker.sv]
// ----------------------------------------------------------------------------
// Telnet receive option negotiator checks
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tnr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_destination,
    input logic [7:0] i_out_byte,
    input logic       i_last
);
    import tnr_pkg::*;

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_destination)
            && $stable(i_out_byte) && $stable(i_last))
        else $error("stalled result changed");

    a_dest_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_destination != DEST_NONE)
        else $error("illegal destination");

    // A notice is a single item with a zero byte.
    a_notice_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_destination == DEST_NOTICE |-> i_out_byte == 8'd0 && i_last)
        else $error("malformed notice");

    // A user data byte is always the only item of its input byte.
    a_user_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_destination == DEST_USER |-> i_last)
        else $error("user data item not last");

endmodule

bind telnet_receive_option_negotiator tnr_checker u_tnr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_destination (o_res.destination),
    .i_out_byte    (o_res.out_byte),
    .i_last        (o_res.last)
);

[bench/tb_telnet_receive_option_negotiator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the telnet receive option negotiator
// Streams received telnet bytes into the block: a short directed sequence,
// then random well-formed commands, negotiations and subnegotiations mixed
// with noise, over several terminal type settings. A tracker class predicts
// every result item and checks the result stream. Bursty input and a
// patterned stalling receiver keep both handshakes busy.
// ----------------------------------------------------------------------------
module tb_telnet_receive_option_negotiator;
    import tnr_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_BYTES   = 48;
    localparam int PAUSE_MARK    = -1;

    typedef struct {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
        logic       line_mode;
        logic       bin_status;
    } t_result;

    // Predicts the result items of each received byte and checks the stream.
    class telnet_reply_tracker;
        logic [31:0]        term_type;
        logic [2:0]         type_len;
        t_phase             phase;
        bit [255:0]         local_on;
        bit [255:0]         remote_on;
        int                 sub_cnt;
        logic [7:0]         sub_opt;
        logic [7:0]         sub_cd;
        logic [7:0]         sub_md;
        logic [FLAGS_W-1:0] flags;
        logic               lm_flag;
        logic [1:0]         step_dest[$];
        logic [7:0]         step_byte[$];
        t_result            replies_due[$];
        int                 mismatches = 0;

        function void reset_state();
            term_type = TERM_TYPE_RST;
            type_len  = TYPE_LENGTH_RST;
            phase     = PH_DATA;
            local_on  = '0;
            remote_on = '0;
            local_on[OPT_BINARY] = 1'b1;
            local_on[OPT_SGA]    = 1'b1;
            sub_cnt   = 0;
            sub_opt   = '0;
            sub_cd    = '0;
            sub_md    = '0;
            flags     = '0;
            lm_flag   = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == CFG_TERM_TYPE) begin
                term_type = val;
            end else if (idx == CFG_TYPE_LENGTH) begin
                type_len = val[2:0];
            end
        endfunction

        function void emit(logic [1:0] d, logic [7:0] b);
            step_dest.push_back(d);
            step_byte.push_back(b);
        endfunction

        // Data bytes inside a reply to the server have IAC doubled.
        function void emit_escaped(logic [7:0] b);
            emit(DEST_SERVER, b);
            if (b == C_IAC) begin
                emit(DEST_SERVER, b);
            end
        endfunction

        function void reply3(logic [7:0] cmd, logic [7:0] opt);
            emit(DEST_SERVER, C_IAC);
            emit(DEST_SERVER, cmd);
            emit(DEST_SERVER, opt);
        endfunction

        function void refresh_line_mode();
            if (flags[F_LM_ACT]) begin
                lm_flag = flags[F_LM_EDT];
            end else if (flags[F_ECHO_R] && flags[F_SGA_R]) begin
                lm_flag = 1'b0;
            end else begin
                lm_flag = 1'b1;
            end
        endfunction

        function void negotiate(t_phase ph, logic [7:0] opt);
            case (ph)
                PH_WILL: begin
                    if (opt == OPT_BINARY || opt == OPT_SGA || opt == OPT_ECHO) begin
                        if (!remote_on[opt]) begin
                            remote_on[opt] = 1'b1;
                            reply3(C_DO, opt);
                            if (opt == OPT_BINARY) flags[F_BIN_R] = 1'b1;
                            else if (opt == OPT_SGA) flags[F_SGA_R] = 1'b1;
                            else flags[F_ECHO_R] = 1'b1;
                        end
                    end else if (remote_on[opt]) begin
                        remote_on[opt] = 1'b0;
                        reply3(C_DONT, opt);
                    end
                end
                PH_WONT: begin
                    if (remote_on[opt]) begin
                        remote_on[opt] = 1'b0;
                        reply3(C_DONT, opt);
                        if (opt == OPT_BINARY) flags[F_BIN_R] = 1'b0;
                        else if (opt == OPT_SGA) flags[F_SGA_R] = 1'b0;
                        else if (opt == OPT_ECHO) flags[F_ECHO_R] = 1'b0;
                        else if (opt == OPT_LINEMODE) flags[F_LM_ACT] = 1'b0;
                    end
                end
                PH_DO: begin
                    if (opt == OPT_BINARY || opt == OPT_SGA || opt == OPT_TTYPE ||
                        opt == OPT_LINEMODE) begin
                        if (!local_on[opt]) begin
                            local_on[opt] = 1'b1;
                            reply3(C_WILL, opt);
                            if (opt == OPT_BINARY) flags[F_BIN_L] = 1'b1;
                            else if (opt == OPT_SGA) flags[F_SGA_L] = 1'b1;
                            else if (opt == OPT_LINEMODE) flags[F_LM_ACT] = 1'b1;
                        end
                    end else if (local_on[opt]) begin
                        local_on[opt] = 1'b0;
                        reply3(C_WONT, opt);
                    end
                end
                default: begin
                    if (local_on[opt]) begin
                        local_on[opt] = 1'b0;
                        reply3(C_WONT, opt);
                        if (opt == OPT_BINARY) flags[F_BIN_L] = 1'b0;
                        else if (opt == OPT_SGA) flags[F_SGA_L] = 1'b0;
                        else if (opt == OPT_LINEMODE) flags[F_LM_ACT] = 1'b0;
                    end
                end
            endcase
            refresh_line_mode();
        endfunction

        // Only the first three subnegotiation bytes are kept.
        function void sub_store(logic [7:0] b);
            if (sub_cnt == 0) sub_opt = b;
            else if (sub_cnt == 1) sub_cd = b;
            else if (sub_cnt == 2) sub_md = b;
            if (sub_cnt < 3) sub_cnt++;
        endfunction

        function void sub_finish();
            int         n;
            int         i;
            logic [7:0] m;
            logic       prev_edit;
            if (sub_cnt < 1) return;
            if (sub_opt == OPT_TTYPE) begin
                if (sub_cnt >= 2 && sub_cd == SUB_SEND) begin
                    n = type_len;
                    if (n > TT_CHARS) n = TT_CHARS;
                    if (n > TYPE_CHARS_DEF) n = TYPE_CHARS_DEF;
                    emit(DEST_SERVER, C_IAC);
                    emit(DEST_SERVER, C_SB);
                    emit(DEST_SERVER, OPT_TTYPE);
                    emit(DEST_SERVER, SUB_IS);
                    for (i = 0; i < n; i++) begin
                        emit_escaped(term_type[31 - 8 * i -: 8]);
                    end
                    emit(DEST_SERVER, C_IAC);
                    emit(DEST_SERVER, C_SE);
                end
            end else if (sub_opt == OPT_LINEMODE) begin
                if (sub_cnt >= 3 && sub_cd == SUB_MODE) begin
                    m = sub_md;
                    prev_edit = flags[F_LM_EDT];
                    flags[F_LM_EDT] = m[MB_EDIT];
                    if (m[MB_ACK]) begin
                        emit(DEST_SERVER, C_IAC);
                        emit(DEST_SERVER, C_SB);
                        emit(DEST_SERVER, OPT_LINEMODE);
                        emit(DEST_SERVER, SUB_MODE);
                        emit_escaped(m);
                        emit(DEST_SERVER, C_IAC);
                        emit(DEST_SERVER, C_SE);
                    end
                    if (prev_edit != flags[F_LM_EDT]) refresh_line_mode();
                end
            end
        endfunction

        function void absorb_rx_byte(logic [7:0] c);
            t_result r;
            step_dest.delete();
            step_byte.delete();
            case (phase)
                PH_DATA: begin
                    if (c == C_IAC) phase = PH_IAC;
                    else emit(DEST_USER, c);
                end
                PH_IAC: begin
                    phase = PH_DATA;
                    if (c == C_IAC) emit(DEST_USER, c);
                    else if (c == C_WILL) phase = PH_WILL;
                    else if (c == C_WONT) phase = PH_WONT;
                    else if (c == C_DO) phase = PH_DO;
                    else if (c == C_DONT) phase = PH_DONT;
                    else if (c == C_SB) begin
                        phase = PH_SB;
                        sub_cnt = 0;
                    end else if (c == C_AYT) emit(DEST_NOTICE, 8'd0);
                end
                PH_WILL, PH_WONT, PH_DO, PH_DONT: begin
                    negotiate(phase, c);
                    phase = PH_DATA;
                end
                PH_SB: begin
                    if (c == C_IAC) phase = PH_SB_IAC;
                    else sub_store(c);
                end
                default: begin
                    if (c == C_SE) begin
                        sub_finish();
                        sub_cnt = 0;
                        phase = PH_DATA;
                    end else begin
                        sub_store(c);
                        phase = PH_SB;
                    end
                end
            endcase
            foreach (step_dest[k]) begin
                r.dest       = step_dest[k];
                r.data       = step_byte[k];
                r.last       = (k == step_dest.size() - 1);
                r.line_mode  = lm_flag;
                r.bin_status = flags[F_BIN_L] | flags[F_BIN_R];
                replies_due.push_back(r);
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task match_result(t_result got);
            t_result want;
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result dest=%0d byte=%02h",
                                        got.dest, got.data));
                return;
            end
            want = replies_due.pop_front();
            if (got.dest !== want.dest || got.data !== want.data || got.last !== want.last ||
                got.line_mode !== want.line_mode || got.bin_status !== want.bin_status) begin
                flag_mismatch($sformatf(
                    "got dest=%0d byte=%02h last=%0b lm=%0b bm=%0b, want %0d %02h %0b %0b %0b",
                    got.dest, got.data, got.last, got.line_mode, got.bin_status,
                    want.dest, want.data, want.last, want.line_mode, want.bin_status));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    tnr_rx_if  rx_ch();
    tnr_res_if res_ch();
    tnr_cfg_if cfg_ch();

    telnet_receive_option_negotiator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    telnet_reply_tracker tracker = new();
    int                  rx_plan[$];
    logic [15:0]         stall_pattern = '1;
    int                  pattern_age = 0;
    int                  quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Result monitor and receiver stall pattern.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.dest       = res_ch.destination;
            got.data       = res_ch.out_byte;
            got.last       = res_ch.last;
            got.line_mode  = res_ch.line_mode;
            got.bin_status = res_ch.bin_status;
            tracker.match_result(got);
        end
        pattern_age <= (pattern_age == 63) ? 0 : pattern_age + 1;
        if (pattern_age == 0) begin
            if ($urandom_range(0, 3) == 0) stall_pattern <= '1;
            else stall_pattern <= 16'($urandom) | 16'h0001;
        end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        end
        res_ch.ready <= stall_pattern[15];
    end

    // Ends the run when no channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk); while (tracker.replies_due.size() != 0);
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] tt, input logic [31:0] len_word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_TERM_TYPE;
        cfg_ch.data  <= tt;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.set_reg(CFG_TERM_TYPE, tt);
        cfg_ch.index <= CFG_TYPE_LENGTH;
        cfg_ch.data  <= len_word;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.set_reg(CFG_TYPE_LENGTH, len_word);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic play_bytes();
        int burst;
        int gap;
        int next;
        burst = $urandom_range(1, 12);
        while (rx_plan.size() != 0) begin
            next = rx_plan.pop_front();
            if (next == PAUSE_MARK) begin
                rx_ch.valid <= 1'b0;
                wait_drained();
                continue;
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= 8'(next);
            do @(posedge i_clk); while (!rx_ch.ready);
            tracker.absorb_rx_byte(8'(next));
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    rx_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            end
        end
    endtask

    function automatic logic [7:0] pick_option();
        logic [7:0] known[5] = '{OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_TTYPE, OPT_LINEMODE};
        if ($urandom_range(0, 4) == 0) return 8'($urandom);
        return known[$urandom_range(0, 4)];
    endfunction

    // A subnegotiation data byte, with IAC doubled as the server would send it.
    function automatic void push_sub(logic [7:0] b);
        if (b == C_IAC) rx_plan.push_back(C_IAC);
        rx_plan.push_back(b);
    endfunction

    function automatic void push_end_sub();
        rx_plan.push_back(C_IAC);
        rx_plan.push_back(C_SE);
    endfunction

    function automatic void add_sequence();
        int         kind;
        int         n;
        logic [7:0] b;
        logic [7:0] cmds[4] = '{C_WILL, C_WONT, C_DO, C_DONT};
        kind = $urandom_range(0, 99);
        if (kind < 24) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                b = 8'($urandom);
                if (b == C_IAC) rx_plan.push_back(C_IAC);
                rx_plan.push_back(b);
            end
        end else if (kind < 50) begin
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(cmds[$urandom_range(0, 3)]);
            rx_plan.push_back(pick_option());
        end else if (kind < 60) begin
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(C_SB);
            rx_plan.push_back(OPT_TTYPE);
            if ($urandom_range(0, 4) != 0) push_sub(SUB_SEND);
            else push_sub(8'($urandom));
            if ($urandom_range(0, 5) == 0) push_sub(8'($urandom));
            push_end_sub();
        end else if (kind < 72) begin
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(C_SB);
            rx_plan.push_back(OPT_LINEMODE);
            if ($urandom_range(0, 5) != 0) push_sub(SUB_MODE);
            else push_sub(8'($urandom));
            if ($urandom_range(0, 7) != 0) push_sub(8'($urandom));
            push_end_sub();
        end else if (kind < 78) begin
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(C_AYT);
        end else if (kind < 86) begin
            // Odd subnegotiation: empty, unknown option, long, or with IAC escapes.
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(C_SB);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                b = (i == 0) ? pick_option() : 8'($urandom);
                if ($urandom_range(0, 3) == 0 && b != C_SE) begin
                    rx_plan.push_back(C_IAC);
                    rx_plan.push_back(b);
                end else begin
                    push_sub(b);
                end
            end
            push_end_sub();
        end else if (kind < 92) begin
            rx_plan.push_back(C_IAC);
            rx_plan.push_back(8'($urandom));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) rx_plan.push_back(8'($urandom));
        end
    endfunction

    function automatic void fill_random(int count);
        int added;
        added = 0;
        while (added < count) begin
            n_before_add: begin
                int start;
                start = rx_plan.size();
                add_sequence();
                added += rx_plan.size() - start;
            end
            if ($urandom_range(0, 24) == 0) rx_plan.push_back(PAUSE_MARK);
        end
    endfunction

    function automatic void load_directed();
        logic [7:0] seq[27] = '{
            8'h00,
            C_IAC, C_IAC,
            C_IAC, C_AYT,
            C_IAC, 8'hF1,
            C_IAC, C_WILL, OPT_ECHO,
            C_IAC, C_DO, OPT_BINARY,
            C_IAC, C_SB, OPT_TTYPE, SUB_SEND, C_IAC, C_SE,
            C_IAC, C_SB, OPT_LINEMODE, SUB_MODE, 8'h05, 8'h07, C_IAC, C_SE
        };
        foreach (seq[i]) rx_plan.push_back(seq[i]);
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_TERM_TYPE;
        cfg_ch.data    = '0;
        tracker.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        fill_random(PHASE_BYTES);
        play_bytes();

        for (int setting = 0; setting < 5; setting++) begin
            settle();
            case (setting)
                // All-IAC terminal type gives the longest reply.
                0: program_regs(32'hFFFF_FFFF, {29'($urandom), 3'd4});
                1: program_regs(32'h0000_0000, {29'($urandom), 3'd1});
                2: program_regs($urandom, {29'($urandom), 3'd0});
                3: program_regs({8'hFF, 24'($urandom)}, {29'($urandom), 3'd7});
                default: program_regs(TERM_TYPE_RST,
                                      {29'($urandom), 3'($urandom_range(1, 3))});
            endcase
            fill_random(PHASE_BYTES);
            play_bytes();
        end

        settle();
        if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/tnr_pkg.sv
rtl/tnr_rx_if.sv
rtl/tnr_res_if.sv
rtl/tnr_cfg_if.sv
rtl/tnr_parser.sv
rtl/tnr_serializer.sv
rtl/telnet_receive_option_negotiator.sv
rtl/tnr_checker.sv
bench/tb_telnet_receive_option_negotiator.sv
